@@ sv/bzp_pkg.sv @@
// bzp_pkg: shared types and constants of the cubic bezier thick pixel plotter
// frame size, register reset values, queue depth and the entry struct
// no dependencies
`default_nettype none

package bzp_pkg;

  // frame size in pixels
  localparam int FRAME_WIDTH  = 800;
  localparam int FRAME_HEIGHT = 600;

  // field widths
  localparam int T_W     = 17;
  localparam int COORD_W = 12;
  localparam int CHAN_W  = 8;
  localparam int REG_W   = 24;
  localparam int IDX_W   = 3;

  // t = 1.0 in Q1.16
  localparam logic [T_W-1:0] ONE_Q16 = 17'd65536;

  // queue between front and back end
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register reset values
  localparam logic [REG_W-1:0] RST_CTRL_PT0    = 24'd205300;
  localparam logic [REG_W-1:0] RST_CTRL_PT1    = 24'd1024050;
  localparam logic [REG_W-1:0] RST_CTRL_PT2    = 24'd2253350;
  localparam logic [REG_W-1:0] RST_CTRL_PT3    = 24'd3072100;
  localparam logic [REG_W-1:0] RST_COLOR_START = 24'd2278750;
  localparam logic [REG_W-1:0] RST_COLOR_END   = 24'd58879;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_CTRL_PT0    = 3'd0,
    CFG_CTRL_PT1    = 3'd1,
    CFG_CTRL_PT2    = 3'd2,
    CFG_CTRL_PT3    = 3'd3,
    CFG_COLOR_START = 3'd4,
    CFG_COLOR_END   = 3'd5
  } cfg_idx_t;

  // configuration as seen by the front end
  typedef struct packed {
    logic [3:0][REG_W-1:0] pt;
    logic [REG_W-1:0]      color_start;
    logic [REG_W-1:0]      color_end;
  } bzp_cfg_t;

  // one evaluated curve point, channel 2 red, 1 green, 0 blue
  typedef struct packed {
    logic [COORD_W-1:0]       cx;
    logic [COORD_W-1:0]       cy;
    logic [2:0][CHAN_W-1:0]   color;
    logic                     in_frame;
  } bzp_pt_t;

endpackage

`default_nettype wire

@@ sv/bzp_in_if.sv @@
// bzp_in_if: request channel carrying the curve parameter
// depends on bzp_pkg
`default_nettype none

interface bzp_in_if import bzp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [T_W-1:0] curve_pos;

  modport source (output valid, output curve_pos, input ready);
  modport sink (input valid, input curve_pos, output ready);
endinterface

`default_nettype wire

@@ sv/bzp_out_if.sv @@
// bzp_out_if: request channel carrying one pixel write
// depends on bzp_pkg
`default_nettype none

interface bzp_out_if import bzp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pix_x;
  logic [COORD_W-1:0] pix_y;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic               last_write;

  modport source (output valid, output pix_x, output pix_y, output red, output green,
                  output blue, output last_write, input ready);
  modport sink (input valid, input pix_x, input pix_y, input red, input green,
                input blue, input last_write, output ready);
endinterface

`default_nettype wire

@@ sv/bzp_front.sv @@
// bzp_front: four-stage pipeline evaluating the cubic bezier point and colour
// depends on bzp_pkg
`default_nettype none

module bzp_front import bzp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [T_W-1:0] curve_pos,
  input  bzp_cfg_t       cfg,
  output logic           push,
  output bzp_pt_t        push_data
);

  function automatic logic [23:0] chan_mul(input logic [CHAN_W-1:0] c,
                                           input logic [T_W-1:0] w);
    logic [24:0] p;
    p = {17'd0, c} * {8'd0, w};
    return p[23:0];
  endfunction

  logic [T_W-1:0]           t_sat;
  logic                     v1_r, v2_r, v3_r, v4_r;
  logic [T_W-1:0]           t1_r, m1_r;
  logic [3:0][COORD_W-1:0]  xs, ys;
  logic [3:0][28:0]         px_r, py_r;
  logic [33:0]              mm, tt;
  logic [32:0]              m2_r, t2_r, m3_r, t3_r;
  logic [2:0][23:0]         cs_r, ce_r;
  logic [2:0][24:0]         csum;
  logic [30:0]              ux_r, vx_r, uy_r, vy_r;
  logic [2:0][CHAN_W-1:0]   col3_r, col4_r;
  logic [63:0]              ax_p, bx_p, ay_p, by_p;
  logic [59:0]              ax_r, bx_r, ay_r, by_r;
  logic [60:0]              sx, sy;
  logic [COORD_W-1:0]       cx, cy;

  assign t_sat = (curve_pos > ONE_Q16) ? ONE_Q16 : curve_pos;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xs[i] = cfg.pt[i][23:12];
      ys[i] = cfg.pt[i][11:0];
    end
  end

  assign mm = {17'd0, m1_r} * {17'd0, m1_r};
  assign tt = {17'd0, t1_r} * {17'd0, t1_r};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      csum[c] = {1'b0, cs_r[c]} + {1'b0, ce_r[c]};
    end
  end

  assign ax_p = {31'd0, m3_r} * {33'd0, ux_r};
  assign bx_p = {31'd0, t3_r} * {33'd0, vx_r};
  assign ay_p = {31'd0, m3_r} * {33'd0, uy_r};
  assign by_p = {31'd0, t3_r} * {33'd0, vy_r};

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // stage 1: saturate t, form 1 - t
    t1_r <= t_sat;
    m1_r <= ONE_Q16 - t_sat;
    // stage 2: coordinate and colour products, squares of m and t
    px_r[0] <= {12'd0, m1_r} * {17'd0, xs[0]};
    px_r[1] <= {12'd0, t1_r} * {17'd0, xs[1]};
    px_r[2] <= {12'd0, m1_r} * {17'd0, xs[2]};
    px_r[3] <= {12'd0, t1_r} * {17'd0, xs[3]};
    py_r[0] <= {12'd0, m1_r} * {17'd0, ys[0]};
    py_r[1] <= {12'd0, t1_r} * {17'd0, ys[1]};
    py_r[2] <= {12'd0, m1_r} * {17'd0, ys[2]};
    py_r[3] <= {12'd0, t1_r} * {17'd0, ys[3]};
    m2_r <= mm[32:0];
    t2_r <= tt[32:0];
    for (int c = 0; c < 3; c++) begin
      cs_r[c] <= chan_mul(cfg.color_start[8*c +: 8], m1_r);
      ce_r[c] <= chan_mul(cfg.color_end[8*c +: 8], t1_r);
    end
    // stage 3: m*p0 + 3t*p1 and 3m*p2 + t*p3, colour truncation
    ux_r <= {2'd0, px_r[0]} + {1'b0, px_r[1], 1'b0} + {2'd0, px_r[1]};
    vx_r <= {1'b0, px_r[2], 1'b0} + {2'd0, px_r[2]} + {2'd0, px_r[3]};
    uy_r <= {2'd0, py_r[0]} + {1'b0, py_r[1], 1'b0} + {2'd0, py_r[1]};
    vy_r <= {1'b0, py_r[2], 1'b0} + {2'd0, py_r[2]} + {2'd0, py_r[3]};
    m3_r <= m2_r;
    t3_r <= t2_r;
    for (int c = 0; c < 3; c++) begin
      col3_r[c] <= csum[c][23:16];
    end
    // stage 4: scale by m^2 and t^2, sum stays below 2^60
    ax_r   <= ax_p[59:0];
    bx_r   <= bx_p[59:0];
    ay_r   <= ay_p[59:0];
    by_r   <= by_p[59:0];
    col4_r <= col3_r;
  end

  // round half up and drop the 48 fraction bits
  assign sx = {1'b0, ax_r} + {1'b0, bx_r} + (61'd1 << 47);
  assign sy = {1'b0, ay_r} + {1'b0, by_r} + (61'd1 << 47);
  assign cx = sx[59:48];
  assign cy = sy[59:48];

  assign push               = v4_r;
  assign push_data.cx       = cx;
  assign push_data.cy       = cy;
  assign push_data.color    = col4_r;
  assign push_data.in_frame = ({1'b0, cx} < 13'(FRAME_WIDTH)) &&
                              ({1'b0, cy} < 13'(FRAME_HEIGHT));

endmodule

`default_nettype wire

@@ sv/bzp_fifo.sv @@
// bzp_fifo: short queue of evaluated points between front and back end
// depends on bzp_pkg
`default_nettype none

module bzp_fifo import bzp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bzp_pt_t push_data,
  input  logic    pop,
  output logic    head_valid,
  output bzp_pt_t head_data
);

  bzp_pt_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  bzp_pt_t             head_r;
  logic                head_valid_r;
  logic                slot_free, take_mem, take_push, mem_push;

  // head register refills from the store, or straight from push when the store is empty
  assign slot_free = !head_valid_r || pop;
  assign take_mem  = slot_free && (count_r != '0);
  assign take_push = slot_free && (count_r == '0) && push;
  assign mem_push  = push && !take_push;

  always_comb begin
    count_nxt = count_r;
    if (mem_push && !take_mem) begin
      count_nxt = count_r + 1'b1;
    end else if (take_mem && !mem_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
      head_valid_r <= 1'b0;
    end else begin
      if (mem_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (take_mem) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
      if (slot_free) begin
        head_valid_r <= take_mem || take_push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (take_mem) begin
      head_r <= mem_r[rd_ptr_r];
    end else if (take_push) begin
      head_r <= push_data;
    end
  end

  assign head_valid = head_valid_r;
  assign head_data  = head_r;

  // credit scheme upstream must never overrun the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_push && (count_r == QCNT_W'(QDEPTH))))
    else $error("bzp_fifo: push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid_r)
    else $error("bzp_fifo: pop from empty queue");

endmodule

`default_nettype wire

@@ sv/bzp_brush.sv @@
// bzp_brush: back end walking the clipped 3x3 brush, one pixel write a cycle unless out_req stalls
// depends on bzp_pkg and bzp_out_if
`default_nettype none

module bzp_brush import bzp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    head_valid,
  input  bzp_pt_t head_data,
  output logic    pop,
  bzp_out_if.source out_req
);

  logic                   busy_r;
  logic [COORD_W-1:0]     x_r, y_r, xhi_r, ylo_r, yhi_r;
  logic [2:0][CHAN_W-1:0] color_r;
  logic                   slot_free, emit, at_last;
  logic [COORD_W-1:0]     hx, hy, hxlo, hxhi, hylo, hyhi;

  logic                   ov_r;
  logic [COORD_W-1:0]     ox_r, oy_r;
  logic [2:0][CHAN_W-1:0] ocol_r;
  logic                   olast_r;

  assign slot_free = !ov_r || out_req.ready;
  assign emit      = busy_r && slot_free;
  assign at_last   = (x_r == xhi_r) && (y_r == yhi_r);
  assign pop       = head_valid && (!busy_r || (emit && at_last));

  // clipped brush bounds of the head entry
  assign hx   = head_data.cx;
  assign hy   = head_data.cy;
  assign hxlo = (hx == '0) ? hx : hx - 1'b1;
  assign hylo = (hy == '0) ? hy : hy - 1'b1;
  assign hxhi = (({1'b0, hx} + 13'd1) < 13'(FRAME_WIDTH)) ? hx + 1'b1 : hx;
  assign hyhi = (({1'b0, hy} + 13'd1) < 13'(FRAME_HEIGHT)) ? hy + 1'b1 : hy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= head_data.in_frame;
      end else if (emit && at_last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_req.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r     <= hxlo;
      y_r     <= hylo;
      xhi_r   <= hxhi;
      ylo_r   <= hylo;
      yhi_r   <= hyhi;
      color_r <= head_data.color;
    end else if (emit) begin
      // dy runs inside dx
      if (y_r == yhi_r) begin
        y_r <= ylo_r;
        x_r <= x_r + 1'b1;
      end else begin
        y_r <= y_r + 1'b1;
      end
    end
    if (emit) begin
      ox_r    <= x_r;
      oy_r    <= y_r;
      ocol_r  <= color_r;
      olast_r <= at_last;
    end
  end

  assign out_req.valid      = ov_r;
  assign out_req.pix_x      = ox_r;
  assign out_req.pix_y      = oy_r;
  assign out_req.red        = ocol_r[2];
  assign out_req.green      = ocol_r[1];
  assign out_req.blue       = ocol_r[0];
  assign out_req.last_write = olast_r;

  // every write lands inside the frame
  a_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (({1'b0, ox_r} < 13'(FRAME_WIDTH)) && ({1'b0, oy_r} < 13'(FRAME_HEIGHT))))
    else $error("bzp_brush: pixel write outside frame");

  // an in-frame point always starts a brush walk
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_data.in_frame) |=> busy_r)
    else $error("bzp_brush: in-frame point dropped");

endmodule

`default_nettype wire

@@ sv/cubic_bezier_thick_pixel_plotter.sv @@
// cubic_bezier_thick_pixel_plotter: top level, configuration registers and credit count
// depends on bzp_pkg, bzp_in_if, bzp_out_if, bzp_front, bzp_fifo, bzp_brush
//
// usage
//   in_req  : request channel with curve_pos, t in unsigned q1.16 (values above 1.0
//             saturate to 1.0); a request is taken when valid and ready are high
//   out_req : request channel of pixel writes (pix_x, pix_y, red, green, blue,
//             last_write); last_write marks the final write of one input request
//   cfg_*   : plain write port, cfg_idx selects ctrl_pt0..3, color_start, color_end;
//             write only while the block is idle, unused indexes are ignored
// timing
//   a four-stage evaluation pipeline feeds an eight-entry queue; the brush walker
//   behind it hands one write per cycle to the output register unless out_req stalls
//   when idle, the first write of a request passes the pipeline stages, the queue head
//   register, the walker registers and the output register; an in-frame point gives
//   four to nine writes (nine away from the frame edge), an out-of-frame point is
//   taken and gives no write; the one-write-per-cycle output port sets the sustained rate
// reset and stall
//   synchronous active-low reset empties pipeline, queue and output register and
//   loads the default control points and colours
//   when out_req stalls the walker holds; ready on in_req drops once eight
//   requests are in flight between acceptance and the queue head
`default_nettype none

module cubic_bezier_thick_pixel_plotter import bzp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bzp_in_if.sink           in_req,
  bzp_out_if.source        out_req,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0] cfg_wdata
);

  bzp_cfg_t            cfg_r;
  logic                in_fire;
  logic                push, pop, head_valid;
  bzp_pt_t             push_data, head_data;
  // requests accepted but not yet taken from the queue
  logic [QCNT_W-1:0]   pending_r, pending_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pt[0]       <= RST_CTRL_PT0;
      cfg_r.pt[1]       <= RST_CTRL_PT1;
      cfg_r.pt[2]       <= RST_CTRL_PT2;
      cfg_r.pt[3]       <= RST_CTRL_PT3;
      cfg_r.color_start <= RST_COLOR_START;
      cfg_r.color_end   <= RST_COLOR_END;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CTRL_PT0:    cfg_r.pt[0]       <= cfg_wdata;
        CFG_CTRL_PT1:    cfg_r.pt[1]       <= cfg_wdata;
        CFG_CTRL_PT2:    cfg_r.pt[2]       <= cfg_wdata;
        CFG_CTRL_PT3:    cfg_r.pt[3]       <= cfg_wdata;
        CFG_COLOR_START: cfg_r.color_start <= cfg_wdata;
        CFG_COLOR_END:   cfg_r.color_end   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // credit: the pipeline never stalls, so room is reserved in the queue on acceptance
  assign in_req.ready = (pending_r < QCNT_W'(QDEPTH));
  assign in_fire      = in_req.valid && in_req.ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_fire && !pop) begin
      pending_nxt = pending_r + 1'b1;
    end else if (pop && !in_fire) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  bzp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .curve_pos (in_req.curve_pos),
    .cfg       (cfg_r),
    .push      (push),
    .push_data (push_data)
  );

  bzp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  bzp_brush u_brush (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_req    (out_req)
  );

  // credit count bounded by the queue depth
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= QCNT_W'(QDEPTH))
    else $error("credit count above queue depth");

endmodule

`default_nettype wire
